// ===== hw/rtl/uart_8n1_transceiver_unit_assert.svh =====
// Assertion macros for the UART transceiver unit.
// Standalone header; used by the top level only.
`ifndef UART_8N1_TRANSCEIVER_UNIT_ASSERT_SVH
`define UART_8N1_TRANSCEIVER_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define U8T_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("u8t assertion failed");

// next-cycle implication, checked outside reset
`define U8T_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("u8t assertion failed");

`endif

// ===== hw/rtl/u8t_pkg.sv =====
// Shared types and constants for the UART transceiver unit.
// No dependencies.
package u8t_pkg;

	localparam int unsigned DataW  = 8;
	localparam int unsigned FrameW = DataW + 2;
	localparam int unsigned BitCntW = 4;

	localparam logic [DataW-1:0] BIT_PERIOD_RESET = 8'd104;
	localparam logic [BitCntW-1:0] RX_DATA_BITS = 4'd8;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_WRITE = 2'd1,
		OP_READ  = 2'd2,
		OP_LINE  = 2'd3
	} op_t;

	typedef struct packed {
		logic [DataW-1:0]   timer_count;
		logic               timer_running;
		logic               sending;
		logic [FrameW-1:0]  tx_frame;
		logic               line_out;
		logic               receiving;
		logic [DataW-1:0]   rx_shift;
		logic [BitCntW-1:0] rx_bits;
		logic               armed;
		logic [DataW-1:0]   held_byte;
		logic               held_full;
	} state_t;

	typedef struct packed {
		logic             tx_level;
		logic             tx_busy;
		logic             rx_busy;
		logic             read_valid;
		logic [DataW-1:0] read_byte;
	} result_t;

	localparam state_t STATE_RESET = '{
		timer_count:   '0,
		timer_running: 1'b0,
		sending:       1'b0,
		tx_frame:      '0,
		line_out:      1'b1,
		receiving:     1'b0,
		rx_shift:      '0,
		rx_bits:       '0,
		armed:         1'b1,
		held_byte:     '0,
		held_full:     1'b0
	};

endpackage

// ===== hw/rtl/uart_8n1_transceiver_unit.sv =====
// UART 8N1 transceiver unit: one registered result per transaction.
// Throughput: one transaction per clock; the next is taken while a result
// waits, as long as the result register is empty or being drained.
// Reset (arst_n low, asynchronous): line idle high, timer stopped, start
// detection armed, nothing held, bit period 104, no result pending.
// Depends on u8t_pkg, u8t_step and uart_8n1_transceiver_unit_assert.svh.
`include "uart_8n1_transceiver_unit_assert.svh"

module uart_8n1_transceiver_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [u8t_pkg::DataW-1:0] cfg_wdata,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [1:0]                opcode,
	input  logic                      rx_level,
	input  logic [u8t_pkg::DataW-1:0] tx_byte,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      tx_level,
	output logic                      tx_busy,
	output logic                      rx_busy,
	output logic                      read_valid,
	output logic [u8t_pkg::DataW-1:0] read_byte
);

	logic [u8t_pkg::DataW-1:0] bit_period_q;
	u8t_pkg::state_t           state_q;
	u8t_pkg::state_t           state_nx;
	u8t_pkg::result_t          res_nx;
	u8t_pkg::result_t          res_q;
	logic                      out_valid_q;
	logic                      in_accept;

	assign in_ready  = !out_valid_q || out_ready;
	assign in_accept = in_valid && in_ready;

	u8t_step u_step (
		.cur        (state_q),
		.bit_period (bit_period_q),
		.op         (u8t_pkg::op_t'(opcode)),
		.level      (rx_level),
		.byte_in    (tx_byte),
		.nxt        (state_nx),
		.res        (res_nx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_period_q <= u8t_pkg::BIT_PERIOD_RESET;
		end else if (cfg_we) begin
			bit_period_q <= cfg_wdata;
		end
	end

	// advance state on every accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= u8t_pkg::STATE_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (in_accept) begin
				state_q <= state_nx;
			end
			if (in_accept) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			res_q <= res_nx;
		end
	end

	assign out_valid  = out_valid_q;
	assign tx_level   = res_q.tx_level;
	assign tx_busy    = res_q.tx_busy;
	assign rx_busy    = res_q.rx_busy;
	assign read_valid = res_q.read_valid;
	assign read_byte  = res_q.read_byte;

	`U8T_ASSERT_NOW(a_armed_vs_rx, clk, arst_n, 1'b1, state_q.receiving != state_q.armed)
	`U8T_ASSERT_NOW(a_timer_busy, clk, arst_n, state_q.sending || state_q.receiving,
		state_q.timer_running)
	`U8T_ASSERT_NOW(a_rbyte_zero, clk, arst_n, out_valid_q && !res_q.read_valid,
		res_q.read_byte == '0)
	`U8T_ASSERT_NEXT(a_read_drains, clk, arst_n, in_accept && res_nx.read_valid,
		!state_q.held_full)

endmodule

// ===== hw/rtl/u8t_step.sv =====
// Next-state and result logic for one transaction of the UART transceiver.
// Depends on u8t_pkg.
module u8t_step (
	input  u8t_pkg::state_t                  cur,
	input  logic [u8t_pkg::DataW-1:0]        bit_period,
	input  u8t_pkg::op_t                     op,
	input  logic                             level,
	input  logic [u8t_pkg::DataW-1:0]        byte_in,
	output u8t_pkg::state_t                  nxt,
	output u8t_pkg::result_t                 res
);

	always_comb begin
		nxt = cur;
		res.read_valid = 1'b0;
		res.read_byte  = '0;
		unique case (op)
			u8t_pkg::OP_TICK: begin
				if (cur.timer_running) begin
					if (cur.timer_count == bit_period) begin
						nxt.timer_count = '0;
						if (!cur.receiving && !cur.sending) begin
							nxt.timer_running = 1'b0;
						end else begin
							if (cur.sending) begin
								if (cur.tx_frame != '0) begin
									nxt.line_out = cur.tx_frame[0];
									nxt.tx_frame = cur.tx_frame >> 1;
								end else begin
									nxt.sending = 1'b0;
								end
							end
							if (cur.receiving) begin
								if (cur.rx_bits >= u8t_pkg::RX_DATA_BITS) begin
									if (level) begin
										nxt.receiving = 1'b0;
										nxt.armed     = 1'b1;
										nxt.rx_bits   = '0;
										nxt.held_byte = cur.rx_shift;
										nxt.held_full = 1'b1;
									end
								end else begin
									nxt.rx_shift = {level, cur.rx_shift[u8t_pkg::DataW-1:1]};
									nxt.rx_bits  = cur.rx_bits + 1'b1;
								end
							end
						end
					end else begin
						nxt.timer_count = cur.timer_count + 1'b1;
					end
				end
			end
			u8t_pkg::OP_WRITE: begin
				if (!cur.sending) begin
					nxt.sending       = 1'b1;
					nxt.tx_frame      = {1'b1, byte_in, 1'b0};
					nxt.timer_count   = '0;
					nxt.timer_running = 1'b1;
				end
			end
			u8t_pkg::OP_READ: begin
				if (!cur.receiving && cur.held_full) begin
					res.read_valid = 1'b1;
					res.read_byte  = cur.held_byte;
					nxt.held_full  = 1'b0;
				end
			end
			u8t_pkg::OP_LINE: begin
				if (cur.armed && !level) begin
					nxt.receiving     = 1'b1;
					nxt.armed         = 1'b0;
					nxt.rx_bits       = '0;
					nxt.timer_count   = '0;
					nxt.timer_running = 1'b1;
				end
			end
			default: ;
		endcase
		res.tx_level = nxt.line_out;
		res.tx_busy  = nxt.sending;
		res.rx_busy  = nxt.receiving;
	end

endmodule

// ===== tb/uart_8n1_transceiver_unit_test.sv =====
// Self-checking testbench for uart_8n1_transceiver_unit: directed and random traffic
// through a queue-fed driver, with a transaction-level shadow of the transceiver checking each result.
// Depends on u8t_pkg and the uart_8n1_transceiver_unit RTL.
module uart_8n1_transceiver_unit_test;

	typedef struct {
		u8t_pkg::op_t op;
		logic         level;
		logic [7:0]   data;
	} uart_op_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_we = 1'b0;
	logic [u8t_pkg::DataW-1:0] cfg_wdata = '0;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	logic [1:0]                opcode = u8t_pkg::OP_TICK;
	logic                      rx_level = 1'b1;
	logic [u8t_pkg::DataW-1:0] tx_byte = '0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic                      tx_level;
	logic                      tx_busy;
	logic                      rx_busy;
	logic                      read_valid;
	logic [u8t_pkg::DataW-1:0] read_byte;

	uart_op_t         uart_ops_q[$];
	u8t_pkg::result_t uart_results_q[$];
	uart_op_t         cur_op;
	u8t_pkg::result_t front_res;
	int               ops_queued = 0;
	int               ops_taken = 0;
	int               results_seen = 0;
	int               mismatches = 0;
	logic [7:0]       sweep_periods[4] = '{8'd1, 8'd2, 8'd0, 8'd5};

	// shadow of the transceiver state
	logic [7:0] bit_cmp = u8t_pkg::BIT_PERIOD_RESET;
	logic [7:0] tmr_cnt = '0;
	logic       tmr_run = 1'b0;
	logic       sending = 1'b0;
	logic [9:0] frame = '0;
	logic       line_q = 1'b1;
	logic       receiving = 1'b0;
	logic [7:0] shift_in = '0;
	logic [3:0] bits_in = '0;
	logic       armed = 1'b1;
	logic [7:0] held = '0;
	logic       held_full = 1'b0;

	uart_8n1_transceiver_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.rx_level(rx_level),
		.tx_byte(tx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.tx_level(tx_level),
		.tx_busy(tx_busy),
		.rx_busy(rx_busy),
		.read_valid(read_valid),
		.read_byte(read_byte)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic shadow_uart_step(input u8t_pkg::op_t op, input logic lvl,
			input logic [7:0] data);
		u8t_pkg::result_t r;
		r = '0;
		case (op)
			u8t_pkg::OP_TICK: begin
				if (tmr_run) begin
					if (tmr_cnt != bit_cmp) begin
						tmr_cnt = tmr_cnt + 8'd1;
					end else begin
						tmr_cnt = '0;
						if (!receiving && !sending) begin
							tmr_run = 1'b0;
						end else begin
							if (sending) begin
								if (frame != '0) begin
									line_q = frame[0];
									frame = frame >> 1;
								end else begin
									sending = 1'b0;
								end
							end
							if (receiving) begin
								if (bits_in >= u8t_pkg::RX_DATA_BITS) begin
									if (lvl) begin
										receiving = 1'b0;
										armed = 1'b1;
										bits_in = '0;
										held = shift_in;
										held_full = 1'b1;
									end
								end else begin
									shift_in = {lvl, shift_in[7:1]};
									bits_in = bits_in + 4'd1;
								end
							end
						end
					end
				end
			end
			u8t_pkg::OP_WRITE: begin
				if (!sending) begin
					sending = 1'b1;
					frame = {1'b1, data, 1'b0};
					tmr_cnt = '0;
					tmr_run = 1'b1;
				end
			end
			u8t_pkg::OP_READ: begin
				if (!receiving && held_full) begin
					r.read_valid = 1'b1;
					r.read_byte = held;
					held_full = 1'b0;
				end
			end
			default: begin
				if (armed && !lvl) begin
					receiving = 1'b1;
					armed = 1'b0;
					bits_in = '0;
					tmr_cnt = '0;
					tmr_run = 1'b1;
				end
			end
		endcase
		r.tx_level = line_q;
		r.tx_busy = sending;
		r.rx_busy = receiving;
		uart_results_q.push_back(r);
	endtask

	task automatic report_mismatch(input string what, input logic [7:0] want,
			input logic [7:0] got);
		$display("%0t mismatch on %s: expected %0h actual %0h", $time, what, want, got);
		mismatches++;
	endtask

	// driver: advance on acceptance, hold otherwise
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				shadow_uart_step(cur_op.op, cur_op.level, cur_op.data);
				ops_taken++;
			end
			if (!in_valid || in_ready) begin
				if (uart_ops_q.size() != 0 && !((ops_taken < 300 || ops_taken >= 600) &&
						$urandom_range(0, 99) < 37)) begin
					cur_op = uart_ops_q.pop_front();
					in_valid <= 1'b1;
					opcode <= cur_op.op;
					rx_level <= cur_op.level;
					tx_byte <= cur_op.data;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: compare each transaction against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (uart_results_q.size() == 0) begin
					$display("%0t unexpected result: expected none actual %b%b%b%b %0h", $time,
						tx_level, tx_busy, rx_busy, read_valid, read_byte);
					mismatches++;
				end else begin
					front_res = uart_results_q.pop_front();
					if (tx_level !== front_res.tx_level)
						report_mismatch("tx_level", 8'(front_res.tx_level), 8'(tx_level));
					if (tx_busy !== front_res.tx_busy)
						report_mismatch("tx_busy", 8'(front_res.tx_busy), 8'(tx_busy));
					if (rx_busy !== front_res.rx_busy)
						report_mismatch("rx_busy", 8'(front_res.rx_busy), 8'(rx_busy));
					if (read_valid !== front_res.read_valid)
						report_mismatch("read_valid", 8'(front_res.read_valid),
							8'(read_valid));
					if (read_byte !== front_res.read_byte)
						report_mismatch("read_byte", front_res.read_byte, read_byte);
				end
				results_seen++;
			end
			out_ready <= !((results_seen < 300 || results_seen >= 600) &&
				$urandom_range(0, 99) < 37);
		end
	end

	task automatic queue_op(input u8t_pkg::op_t op, input logic lvl, input logic [7:0] data);
		uart_op_t it;
		it.op = op;
		it.level = lvl;
		it.data = data;
		uart_ops_q.push_back(it);
		ops_queued++;
	endtask

	task automatic queue_ticks(input int n, input logic lvl);
		for (int i = 0; i < n; i++)
			queue_op(u8t_pkg::OP_TICK, lvl, 8'($urandom));
	endtask

	task automatic queue_rx_frame(input logic [7:0] data, input int stop_low);
		queue_op(u8t_pkg::OP_LINE, 1'b0, 8'($urandom));
		for (int i = 0; i < 8; i++)
			queue_ticks(int'(bit_cmp) + 1, data[i]);
		queue_ticks(stop_low, 1'b0);
		queue_ticks(int'(bit_cmp) + 1, 1'b1);
		queue_op(u8t_pkg::OP_READ, 1'($urandom), 8'($urandom));
	endtask

	task automatic queue_random_traffic(input int budget);
		int start;
		int k;
		start = ops_queued;
		while (ops_queued < start + budget) begin
			k = $urandom_range(0, 99);
			if (k < 40) begin
				if ($urandom_range(0, 3) == 0)
					queue_op(u8t_pkg::OP_WRITE, 1'($urandom), 8'($urandom));
				queue_rx_frame(8'($urandom),
					($urandom_range(0, 2) == 0) ? $urandom_range(1, 2 * (int'(bit_cmp) + 1)) : 0);
			end else if (k < 65) begin
				queue_op(u8t_pkg::OP_WRITE, 1'($urandom), 8'($urandom));
				for (int i = ($urandom_range(1, 12)) * (int'(bit_cmp) + 1); i > 0; i--)
					queue_op(u8t_pkg::OP_TICK, 1'($urandom), 8'($urandom));
			end else if (k < 80) begin
				queue_op(u8t_pkg::OP_READ, 1'($urandom), 8'($urandom));
			end else begin
				for (int i = $urandom_range(1, 4); i > 0; i--)
					queue_op(u8t_pkg::op_t'($urandom_range(0, 3)), 1'($urandom), 8'($urandom));
			end
		end
	endtask

	task automatic settle();
		while (uart_ops_q.size() != 0 || in_valid || uart_results_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_bit_period(input logic [7:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		bit_cmp = value;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// reset bit period: idle cases, ignored write, start while sending
		queue_op(u8t_pkg::OP_TICK, 1'b1, 8'h00);
		queue_op(u8t_pkg::OP_READ, 1'b0, 8'h00);
		queue_op(u8t_pkg::OP_LINE, 1'b1, 8'h00);
		queue_op(u8t_pkg::OP_WRITE, 1'b0, 8'hFF);
		queue_op(u8t_pkg::OP_WRITE, 1'b1, 8'h00);
		queue_ticks(2, 1'b0);
		queue_op(u8t_pkg::OP_LINE, 1'b0, 8'hFF);
		queue_op(u8t_pkg::OP_READ, 1'b1, 8'hFF);
		queue_op(u8t_pkg::OP_LINE, 1'b0, 8'h00);
		settle();

		// zero period: zero byte received, low stop waits, timer stops when idle
		write_bit_period(8'd0);
		queue_ticks(9, 1'b0);
		queue_ticks(1, 1'b1);
		queue_op(u8t_pkg::OP_READ, 1'b0, 8'h00);
		queue_op(u8t_pkg::OP_READ, 1'b1, 8'hFF);
		queue_ticks(3, 1'b1);
		queue_rx_frame(8'hFF, 0);
		settle();

		foreach (sweep_periods[i]) begin
			write_bit_period(sweep_periods[i]);
			queue_random_traffic(70);
			settle();
		end

		// drop the period below a running count so it wraps
		write_bit_period(8'd255);
		queue_op(u8t_pkg::OP_WRITE, 1'b1, 8'h5A);
		queue_ticks(200, 1'b1);
		settle();
		write_bit_period(8'd3);
		queue_random_traffic(70);
		settle();

		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#400000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/u8t_pkg.sv
hw/rtl/u8t_step.sv
hw/rtl/uart_8n1_transceiver_unit.sv
tb/uart_8n1_transceiver_unit_test.sv
